// File: src/assert_macros.svh
// Assertion macros shared by the scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BIDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BIDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bids_pkg.sv
// Package of types and constants for the bilinear image downscaler.
package bids_pkg;

  // Field widths of the words on the channels.
  localparam int OP_W       = 1;
  localparam int INDEX_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int DST_W      = 12;
  localparam int CHAN_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register widths.
  localparam int DIM_W  = 13;
  localparam int STEP_W = 29;
  localparam int BPP_W  = 3;

  // Default parameter values.
  localparam int MAX_SRC_BYTES_DEF = 65536;
  localparam int FRAC_BITS_DEF     = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd4;

  // Register reset values.
  localparam logic [DIM_W-1:0]  DIM_RESET  = 13'd1;
  localparam logic [STEP_W-1:0] STEP_RESET = 29'h0001_0000;
  localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd1;

  // Input word: a load or a request.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] src_index;
    logic [BYTE_W-1:0]  src_byte;
    logic [DST_W-1:0]   dst_x;
    logic [DST_W-1:0]   dst_y;
    logic [CHAN_W-1:0]  channel;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
  } out_word_t;

  // Configuration write word.
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_word_t;

endpackage

// File: src/bids_stream_if.sv
// Valid/ready channel interface carrying one word of a given type.
interface bids_stream_if #(
  parameter type data_t = logic
) ();

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// File: src/bids_ram.sv
// Generic single-port synchronous RAM with a registered read.
module bids_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One address per cycle: a write when enabled, and always a read with the data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/bilinear_image_downscaler.sv
// Top level of the bilinear image downscaler with its source byte store.
//
//   channel  direction  word                                           handshake
//   in_ch    sink       op, src_index, src_byte, dst_x, dst_y, channel valid/ready
//   out_ch   source     out_byte                                       valid/ready
//   cfg_ch   sink       index, wdata                                   valid/ready
//
// A load writes the byte into the store at acceptance.
// A request keeps the block busy through the position, clamp and weight arithmetic
// states, then a memory phase in which the single-port store is read four times and
// the weighted bytes are multiplied and summed; the output state registers the result.
// Reset is synchronous and active low; it clears the state, output and config registers.
// A finished result waits in the output register; loads are still taken meanwhile, and a
// following request stalls only in its output state while that register is full.
`include "assert_macros.svh"

module bilinear_image_downscaler #(
  parameter int MAX_SRC_BYTES = bids_pkg::MAX_SRC_BYTES_DEF,
  parameter int FRAC_BITS     = bids_pkg::FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  bids_stream_if.sink   in_ch,
  bids_stream_if.source out_ch,
  bids_stream_if.sink   cfg_ch
);

  localparam int ADDR_W   = $clog2(MAX_SRC_BYTES);
  localparam int DIM_W    = bids_pkg::DIM_W;
  localparam int STEP_W   = bids_pkg::STEP_W;
  localparam int BPP_W    = bids_pkg::BPP_W;
  localparam int DST_W    = bids_pkg::DST_W;
  localparam int BYTE_W   = bids_pkg::BYTE_W;
  localparam int CHAN_W   = bids_pkg::CHAN_W;
  localparam int POS_W    = DST_W + STEP_W;
  localparam int IP_W     = POS_W - FRAC_BITS;
  localparam int STRIDE_W = DIM_W + BPP_W;
  localparam int NADDR_W  = STRIDE_W + DIM_W;
  localparam int COL_W    = DIM_W + BPP_W;
  localparam int WT_W     = FRAC_BITS + 1;
  localparam int WGT_W    = 2 * WT_W;
  localparam int PROD_W   = WGT_W + BYTE_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int RES_W    = ACC_W - 2 * FRAC_BITS;

  localparam logic [STEP_W-1:0] ONE_STEP = STEP_W'(64'd1 << FRAC_BITS);
  localparam logic [WT_W-1:0]   ONE_WT   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [2:0]        MEM_LAST = 3'd5;
  localparam logic [2:0]        MEM_RDS  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_ROW,
    S_MEM,
    S_OUT
  } state_t;

  state_t state_r;
  logic [2:0] cnt_r;
  logic out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;

  // Configuration registers.
  logic [DIM_W-1:0]  width_r, height_r;
  logic [STEP_W-1:0] x_step_r, y_step_r;
  logic [BPP_W-1:0]  bpp_r;

  // Request datapath registers.
  logic [DST_W-1:0]    dx_r, dy_r;
  logic [CHAN_W-1:0]   ch_r;
  logic                zero_r;
  logic [POS_W-1:0]    posx_r, posy_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [DIM_W-1:0]    x0_r, x1_r, y0_r, y1_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic [NADDR_W-1:0]  row0_r, row1_r;
  logic [COL_W-1:0]    col0_r, col1_r;
  logic [WGT_W-1:0]    wgt_r [4];
  logic                oob_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ACC_W-1:0]    acc_r;

  // Combinational signals.
  logic in_acc, cfg_acc, out_free, out_load;
  logic [DIM_W-1:0]  w_eff, h_eff, last_x, last_y;
  logic [BPP_W-1:0]  b_eff;
  logic [STEP_W-1:0] sx, sy;
  logic [IP_W-1:0]   ipx, ipy;
  logic [DIM_W-1:0]  x0_c, x1_c, y0_c, y1_c;
  logic [FRAC_BITS-1:0] fx_c, fy_c;
  logic [WT_W-1:0]   omfx, omfy, fx_w, fy_w;
  logic [NADDR_W-1:0] naddr;
  logic              oob_c;
  logic [1:0]        wsel;
  logic [BYTE_W-1:0] byte_v;
  logic [RES_W-1:0]  res_wide;
  logic [BYTE_W-1:0] res_byte;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == S_OUT) && out_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data.out_byte = out_byte_r;

  // Effective geometry: zero sizes count as one, channel count held to 1..4, steps at least one.
  always_comb begin
    w_eff = (width_r == '0) ? DIM_W'(1) : width_r;
    h_eff = (height_r == '0) ? DIM_W'(1) : height_r;
    priority if (bpp_r == '0) begin
      b_eff = BPP_W'(1);
    end else if (bpp_r > BPP_W'(4)) begin
      b_eff = BPP_W'(4);
    end else begin
      b_eff = bpp_r;
    end
    last_x = w_eff - DIM_W'(1);
    last_y = h_eff - DIM_W'(1);
    sx = (x_step_r < ONE_STEP) ? ONE_STEP : x_step_r;
    sy = (y_step_r < ONE_STEP) ? ONE_STEP : y_step_r;
  end

  // Clamp the integer positions to the image and pick the right and lower neighbours.
  always_comb begin
    ipx = posx_r[POS_W-1:FRAC_BITS];
    ipy = posy_r[POS_W-1:FRAC_BITS];
    if (ipx > IP_W'(last_x)) begin
      x0_c = last_x;
      fx_c = '0;
    end else begin
      x0_c = ipx[DIM_W-1:0];
      fx_c = posx_r[FRAC_BITS-1:0];
    end
    if (ipy > IP_W'(last_y)) begin
      y0_c = last_y;
      fy_c = '0;
    end else begin
      y0_c = ipy[DIM_W-1:0];
      fy_c = posy_r[FRAC_BITS-1:0];
    end
    x1_c = (x0_c == last_x) ? x0_c : x0_c + DIM_W'(1);
    y1_c = (y0_c == last_y) ? y0_c : y0_c + DIM_W'(1);
  end

  // Weight factors of the fractions.
  always_comb begin
    fx_w = {1'b0, fx_r};
    fy_w = {1'b0, fy_r};
    omfx = ONE_WT - fx_w;
    omfy = ONE_WT - fy_w;
  end

  // Neighbour address: the read count selects the row in its bit 1, the column
  // in its bit 0, in the same order as the weights.
  always_comb begin
    naddr = (cnt_r[1] ? row1_r : row0_r)
          + NADDR_W'(cnt_r[0] ? col1_r : col0_r);
    oob_c = 64'(naddr) >= 64'(MAX_SRC_BYTES);
    wsel  = 2'(cnt_r - 3'd1);
    byte_v = oob_r ? '0 : ram_rdata;
  end

  // Truncate and saturate the blended sum.
  always_comb begin
    res_wide = acc_r[ACC_W-1:2*FRAC_BITS];
    res_byte = (res_wide > RES_W'(255)) ? BYTE_W'(255) : res_wide[BYTE_W-1:0];
  end

  // Store port: loads write while idle, requests read while in the memory phase.
  always_comb begin
    ram_we = in_acc && (in_ch.data.op == bids_pkg::OP_LOAD)
          && (64'(in_ch.data.src_index) < 64'(MAX_SRC_BYTES));
    if (state_r == S_IDLE) begin
      ram_addr = ADDR_W'(in_ch.data.src_index);
    end else begin
      ram_addr = ADDR_W'(naddr);
    end
  end

  bids_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_SRC_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_ch.data.src_byte),
    .rdata(ram_rdata)
  );

  // Configuration registers, written whenever a word arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bids_pkg::DIM_RESET;
      height_r <= bids_pkg::DIM_RESET;
      x_step_r <= bids_pkg::STEP_RESET;
      y_step_r <= bids_pkg::STEP_RESET;
      bpp_r    <= bids_pkg::BPP_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_ch.data.index)
        bids_pkg::CFG_SRC_WIDTH:  width_r  <= cfg_ch.data.wdata[DIM_W-1:0];
        bids_pkg::CFG_SRC_HEIGHT: height_r <= cfg_ch.data.wdata[DIM_W-1:0];
        bids_pkg::CFG_X_STEP:     x_step_r <= cfg_ch.data.wdata[STEP_W-1:0];
        bids_pkg::CFG_Y_STEP:     y_step_r <= cfg_ch.data.wdata[STEP_W-1:0];
        bids_pkg::CFG_BPP:        bpp_r    <= cfg_ch.data.wdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: state, read count and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_byte_r  <= '0;
    end else begin
      // A finished result fills the output register; a taken word empties it.
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= zero_r ? '0 : res_byte;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.data.op == bids_pkg::OP_REQUEST)) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_CLAMP;
        S_CLAMP: state_r <= S_ROW;
        S_ROW: begin
          state_r <= S_MEM;
          cnt_r   <= '0;
        end
        S_MEM: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == MEM_LAST) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Request datapath: one arithmetic step per state.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.data.op == bids_pkg::OP_REQUEST)) begin
          dx_r   <= in_ch.data.dst_x;
          dy_r   <= in_ch.data.dst_y;
          ch_r   <= in_ch.data.channel;
          zero_r <= BPP_W'(in_ch.data.channel) >= b_eff;
        end
      end
      S_MUL: begin
        posx_r   <= POS_W'(dx_r) * POS_W'(sx);
        posy_r   <= POS_W'(dy_r) * POS_W'(sy);
        stride_r <= STRIDE_W'(w_eff) * STRIDE_W'(b_eff);
      end
      S_CLAMP: begin
        x0_r <= x0_c;
        x1_r <= x1_c;
        y0_r <= y0_c;
        y1_r <= y1_c;
        fx_r <= fx_c;
        fy_r <= fy_c;
      end
      S_ROW: begin
        row0_r   <= NADDR_W'(stride_r) * NADDR_W'(y0_r);
        row1_r   <= NADDR_W'(stride_r) * NADDR_W'(y1_r);
        col0_r   <= COL_W'(x0_r) * COL_W'(b_eff) + COL_W'(ch_r);
        col1_r   <= COL_W'(x1_r) * COL_W'(b_eff) + COL_W'(ch_r);
        wgt_r[0] <= WGT_W'(omfx) * WGT_W'(omfy);
        wgt_r[1] <= WGT_W'(fx_w) * WGT_W'(omfy);
        wgt_r[2] <= WGT_W'(omfx) * WGT_W'(fy_w);
        wgt_r[3] <= WGT_W'(fx_w) * WGT_W'(fy_w);
        acc_r    <= '0;
      end
      S_MEM: begin
        oob_r <= oob_c;
        if ((cnt_r != 3'd0) && (cnt_r <= MEM_RDS)) begin
          prod_r <= PROD_W'(wgt_r[wsel]) * PROD_W'(byte_v);
        end
        if (cnt_r >= 3'd2) begin
          acc_r <= acc_r + ACC_W'(prod_r);
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // The store has one port: it is written only while the block is idle.
  `BIDS_ASSERT_IMPL(a_write_idle, clk, rst_n, ram_we, state_r == S_IDLE,
                    "store written outside idle")
  // The read count never passes its last value during the memory phase.
  `BIDS_ASSERT_IMPL(a_cnt_range, clk, rst_n, state_r == S_MEM, cnt_r <= MEM_LAST,
                    "read count overran")
  // An accepted request starts the arithmetic in the next cycle.
  `BIDS_ASSERT_NEXT(a_req_start, clk, rst_n,
                    in_acc && (in_ch.data.op == bids_pkg::OP_REQUEST),
                    state_r == S_MUL, "request did not start")
  // A finished request with a free output register shows its result next cycle.
  `BIDS_ASSERT_NEXT(a_result_out, clk, rst_n, (state_r == S_OUT) && out_free,
                    out_valid_r && (state_r == S_IDLE), "result not presented")

endmodule
